// ===== rtl/msb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_pkg
// shared types and constants for the metal shine band pixel blend
// ----------------------------------------------------------------------------
package msb_pkg;

    localparam int COORD_BITS    = 12;
    localparam int BAND_BITS_DEF = 10;
    localparam int POS_BITS      = 14;
    localparam int PCT_BITS      = 7;
    localparam int CHAN_BITS     = 8;
    localparam int NCH           = 3;
    localparam int K_BITS        = ((COORD_BITS + 1 > POS_BITS) ? COORD_BITS + 1 : POS_BITS) + 2;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 14;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_DIRECTION     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BAND_SIZE     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRAD_PERCENT  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BRIGHT_RED    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_BRIGHT_GREEN  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_BRIGHT_BLUE   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_BAND_POSITION = 3'd6;

    localparam int                    BAND_SIZE_RST = 64;
    localparam logic [PCT_BITS-1:0]   GRAD_PCT_RST  = 7'd25;
    localparam logic [CHAN_BITS-1:0]  BRIGHT_RST    = 8'hFF;
    localparam logic [POS_BITS-1:0]   POS_RST       = 14'd0;

    // floor(x / 100) as (x * GRAD_RECIP) >> GRAD_SHIFT, exact for x below 2^20
    localparam int                    RECIP_BITS = 20;
    localparam logic [RECIP_BITS-1:0] GRAD_RECIP = 20'd671089;
    localparam int                    GRAD_SHIFT = 26;

    localparam logic [CHAN_BITS-1:0] CHAN_MAX     = 8'hFF;
    localparam logic [CHAN_BITS-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [CHAN_BITS-1:0] ALPHA_CLEAR  = 8'h00;
    localparam logic [CHAN_BITS:0]   ALPHA_ONE    = 9'd256;

    typedef enum logic [1:0] {
        DIR_ROW  = 2'd0,
        DIR_COL  = 2'd1,
        DIR_DIFF = 2'd2,
        DIR_SUM  = 2'd3
    } dir_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pix_x;
        logic [COORD_BITS-1:0] pix_y;
        logic [CHAN_BITS-1:0]  src_red;
        logic [CHAN_BITS-1:0]  src_green;
        logic [CHAN_BITS-1:0]  src_blue;
        logic [CHAN_BITS-1:0]  alpha;
        logic [CHAN_BITS-1:0]  dst_red;
        logic [CHAN_BITS-1:0]  dst_green;
        logic [CHAN_BITS-1:0]  dst_blue;
    } pix_in_t;

    typedef struct packed {
        logic [CHAN_BITS-1:0] out_red;
        logic [CHAN_BITS-1:0] out_green;
        logic [CHAN_BITS-1:0] out_blue;
        logic                 write_enable;
    } pix_out_t;

    typedef struct packed {
        logic [NCH-1:0][CHAN_BITS-1:0] src;
        logic [CHAN_BITS-1:0]          alpha;
        logic [NCH-1:0][CHAN_BITS-1:0] dst;
    } pix_carry_t;

    typedef struct packed {
        logic in_band;
        logic full;
    } tint_ctl_t;

endpackage

// ===== rtl/msb_band.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_band
// band offset, edge ramp selection and tint numerator, four stages
// ----------------------------------------------------------------------------
module msb_band #(
    parameter int BAND_BITS = msb_pkg::BAND_BITS_DEF
) (
    input  logic                                                 aclk,
    input  logic [3:0]                                           stage_en,
    input  msb_pkg::pix_in_t                                     pix_in,
    input  msb_pkg::dir_t                                        direction,
    input  logic [BAND_BITS-1:0]                                 band_size,
    input  logic [msb_pkg::POS_BITS-1:0]                         band_position,
    input  logic [BAND_BITS:0]                                   grad,
    input  logic [msb_pkg::NCH-1:0][msb_pkg::CHAN_BITS-1:0]      bright,
    output msb_pkg::pix_carry_t                                  carry_out,
    output msb_pkg::tint_ctl_t                                   ctl_out,
    output logic [msb_pkg::NCH-1:0][BAND_BITS:0]                 rem_out,
    output logic [msb_pkg::NCH-1:0][msb_pkg::CHAN_BITS-1:0]      nb_out
);

    localparam int KW  = msb_pkg::K_BITS;
    localparam int CW  = msb_pkg::COORD_BITS;
    localparam int PB  = msb_pkg::POS_BITS;
    localparam int GW  = BAND_BITS + 1;
    localparam int NW  = BAND_BITS + msb_pkg::CHAN_BITS;
    localparam int CHB = msb_pkg::CHAN_BITS;

    // stage 0: offset along the sweep axis
    logic signed [KW-1:0] x_ext, y_ext, pos_ext, k_next;
    logic signed [KW-1:0] k_reg;
    msb_pkg::pix_carry_t  carry_next, carry0_reg, carry1_reg, carry2_reg, carry3_reg;

    always_comb begin
        x_ext   = $signed({{(KW-CW){1'b0}}, pix_in.pix_x});
        y_ext   = $signed({{(KW-CW){1'b0}}, pix_in.pix_y});
        pos_ext = $signed({{(KW-PB){band_position[PB-1]}}, band_position});
        unique case (direction)
            msb_pkg::DIR_ROW:  k_next = y_ext - pos_ext;
            msb_pkg::DIR_COL:  k_next = x_ext - pos_ext;
            msb_pkg::DIR_DIFF: k_next = x_ext - y_ext - pos_ext;
            msb_pkg::DIR_SUM:  k_next = x_ext + y_ext - pos_ext;
            default:           k_next = '0;
        endcase
        carry_next.src[msb_pkg::CH_RED]   = pix_in.src_red;
        carry_next.src[msb_pkg::CH_GREEN] = pix_in.src_green;
        carry_next.src[msb_pkg::CH_BLUE]  = pix_in.src_blue;
        carry_next.alpha                  = pix_in.alpha;
        carry_next.dst[msb_pkg::CH_RED]   = pix_in.dst_red;
        carry_next.dst[msb_pkg::CH_GREEN] = pix_in.dst_green;
        carry_next.dst[msb_pkg::CH_BLUE]  = pix_in.dst_blue;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            k_reg      <= k_next;
            carry0_reg <= carry_next;
        end
    end

    // stage 1: band membership and distance to the far edge
    logic                 inside_next, inside1_reg;
    logic [BAND_BITS-1:0] kk_next, kk_reg, sk_next, sk_reg;

    always_comb begin
        inside_next = !k_reg[KW-1] && (k_reg[KW-2:0] <= (KW-1)'(band_size));
        kk_next     = k_reg[BAND_BITS-1:0];
        sk_next     = band_size - kk_next;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            inside1_reg <= inside_next;
            kk_reg      <= kk_next;
            sk_reg      <= sk_next;
            carry1_reg  <= carry0_reg;
        end
    end

    // stage 2: rising or falling edge ramp
    logic                 ramp_up, ramp_dn;
    logic [BAND_BITS-1:0] m_next, m_reg;
    msb_pkg::tint_ctl_t   ctl2_next, ctl2_reg, ctl3_reg;

    always_comb begin
        ramp_up = (grad != '0) && ({1'b0, kk_reg} < grad);
        ramp_dn = (grad != '0) && !ramp_up &&
                  (({1'b0, 1'b0, kk_reg} + {1'b0, grad}) >= {1'b0, 1'b0, band_size});
        m_next            = ramp_up ? kk_reg : sk_reg;
        ctl2_next.in_band = inside1_reg;
        ctl2_next.full    = !(ramp_up || ramp_dn);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            m_reg      <= m_next;
            ctl2_reg   <= ctl2_next;
            carry2_reg <= carry1_reg;
        end
    end

    // stage 3: peak times ramp position, split for the divider
    logic [msb_pkg::NCH-1:0][NW-1:0]  prod;
    logic [msb_pkg::NCH-1:0][GW-1:0]  rem_next, rem_reg;
    logic [msb_pkg::NCH-1:0][CHB-1:0] nb_next, nb_reg;

    always_comb begin
        for (int c = 0; c < msb_pkg::NCH; c++) begin
            prod[c]     = NW'(bright[c]) * NW'(m_reg);
            rem_next[c] = GW'(prod[c][NW-1:CHB]);
            nb_next[c]  = prod[c][CHB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            rem_reg    <= rem_next;
            nb_reg     <= nb_next;
            ctl3_reg   <= ctl2_reg;
            carry3_reg <= carry2_reg;
        end
    end

    assign carry_out = carry3_reg;
    assign ctl_out   = ctl3_reg;
    assign rem_out   = rem_reg;
    assign nb_out    = nb_reg;

endmodule

// ===== rtl/msb_div_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_div_stage
// one registered slice of the restoring tint divider, all three channels
// ----------------------------------------------------------------------------
module msb_div_stage #(
    parameter int BAND_BITS = msb_pkg::BAND_BITS_DEF,
    parameter int STEPS     = 2
) (
    input  logic                                                 aclk,
    input  logic                                                 stage_en,
    input  logic [BAND_BITS:0]                                   grad,
    input  msb_pkg::pix_carry_t                                  carry_in,
    input  msb_pkg::tint_ctl_t                                   ctl_in,
    input  logic [msb_pkg::NCH-1:0][BAND_BITS:0]                 rem_in,
    input  logic [msb_pkg::NCH-1:0][msb_pkg::CHAN_BITS-1:0]      nb_in,
    input  logic [msb_pkg::NCH-1:0][msb_pkg::CHAN_BITS-1:0]      q_in,
    output msb_pkg::pix_carry_t                                  carry_out,
    output msb_pkg::tint_ctl_t                                   ctl_out,
    output logic [msb_pkg::NCH-1:0][BAND_BITS:0]                 rem_out,
    output logic [msb_pkg::NCH-1:0][msb_pkg::CHAN_BITS-1:0]      nb_out,
    output logic [msb_pkg::NCH-1:0][msb_pkg::CHAN_BITS-1:0]      q_out
);

    localparam int GW  = BAND_BITS + 1;
    localparam int CHB = msb_pkg::CHAN_BITS;

    logic [msb_pkg::NCH-1:0][GW-1:0]  rem_next, rem_reg;
    logic [msb_pkg::NCH-1:0][CHB-1:0] nb_next, nb_reg, q_next, q_reg;
    msb_pkg::pix_carry_t              carry_reg;
    msb_pkg::tint_ctl_t               ctl_reg;

    always_comb begin
        logic [GW-1:0]  r;
        logic [GW:0]    t;
        logic [CHB-1:0] b;
        logic [CHB-1:0] q;
        for (int c = 0; c < msb_pkg::NCH; c++) begin
            r = rem_in[c];
            b = nb_in[c];
            q = q_in[c];
            for (int s = 0; s < STEPS; s++) begin
                t = {r, b[CHB-1]};
                b = {b[CHB-2:0], 1'b0};
                if (t >= {1'b0, grad}) begin
                    t = t - {1'b0, grad};
                    q = {q[CHB-2:0], 1'b1};
                end else begin
                    q = {q[CHB-2:0], 1'b0};
                end
                r = t[GW-1:0];
            end
            rem_next[c] = r;
            nb_next[c]  = b;
            q_next[c]   = q;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en) begin
            rem_reg   <= rem_next;
            nb_reg    <= nb_next;
            q_reg     <= q_next;
            carry_reg <= carry_in;
            ctl_reg   <= ctl_in;
        end
    end

    assign carry_out = carry_reg;
    assign ctl_out   = ctl_reg;
    assign rem_out   = rem_reg;
    assign nb_out    = nb_reg;
    assign q_out     = q_reg;

endmodule

// ===== rtl/msb_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_blend
// tint select, saturating add and alpha blend onto the destination
// ----------------------------------------------------------------------------
module msb_blend (
    input  logic                                                 aclk,
    input  logic [2:0]                                           stage_en,
    input  msb_pkg::pix_carry_t                                  carry_in,
    input  msb_pkg::tint_ctl_t                                   ctl_in,
    input  logic [msb_pkg::NCH-1:0][msb_pkg::CHAN_BITS-1:0]      q_in,
    input  logic [msb_pkg::NCH-1:0][msb_pkg::CHAN_BITS-1:0]      bright,
    output msb_pkg::pix_out_t                                    result
);

    localparam int CHB = msb_pkg::CHAN_BITS;
    localparam int NCH = msb_pkg::NCH;

    // stage a: tint and saturating add
    logic [NCH-1:0][CHB-1:0] tint, s_next, sa_s_reg, sb_s_reg;
    logic [NCH-1:0][CHB:0]   sum;
    logic [CHB-1:0]          alpha_a_reg, alpha_b_reg;
    logic [NCH-1:0][CHB-1:0] dst_a_reg, dst_b_reg;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            if (!ctl_in.in_band) begin
                tint[c] = '0;
            end else if (ctl_in.full) begin
                tint[c] = bright[c];
            end else begin
                tint[c] = q_in[c];
            end
            sum[c]    = {1'b0, carry_in.src[c]} + {1'b0, tint[c]};
            s_next[c] = sum[c][CHB] ? msb_pkg::CHAN_MAX : sum[c][CHB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            sa_s_reg    <= s_next;
            alpha_a_reg <= carry_in.alpha;
            dst_a_reg   <= carry_in.dst;
        end
    end

    // stage b: weighting products
    logic [CHB:0]              inv_alpha;
    logic [NCH-1:0][2*CHB-1:0] src_w_next, src_w_reg;
    logic [NCH-1:0][2*CHB:0]   dst_w_next, dst_w_reg;

    always_comb begin
        inv_alpha = msb_pkg::ALPHA_ONE - {1'b0, alpha_a_reg};
        for (int c = 0; c < NCH; c++) begin
            src_w_next[c] = (2*CHB)'(sa_s_reg[c]) * (2*CHB)'(alpha_a_reg);
            dst_w_next[c] = (2*CHB+1)'(dst_a_reg[c]) * (2*CHB+1)'(inv_alpha);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            src_w_reg   <= src_w_next;
            dst_w_reg   <= dst_w_next;
            sb_s_reg    <= sa_s_reg;
            dst_b_reg   <= dst_a_reg;
            alpha_b_reg <= alpha_a_reg;
        end
    end

    // stage c: sum, clamp and alpha special cases
    logic [NCH-1:0][CHB+1:0] v;
    logic [NCH-1:0][CHB-1:0] col;
    msb_pkg::pix_out_t       res_next, res_reg;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            v[c] = (CHB+2)'(src_w_reg[c][2*CHB-1:CHB]) + (CHB+2)'(dst_w_reg[c][2*CHB:CHB]);
            if (alpha_b_reg == msb_pkg::ALPHA_CLEAR) begin
                col[c] = dst_b_reg[c];
            end else if (alpha_b_reg == msb_pkg::ALPHA_OPAQUE) begin
                col[c] = sb_s_reg[c];
            end else if (v[c] > (CHB+2)'(msb_pkg::CHAN_MAX)) begin
                col[c] = msb_pkg::CHAN_MAX;
            end else begin
                col[c] = v[c][CHB-1:0];
            end
        end
        res_next.out_red      = col[msb_pkg::CH_RED];
        res_next.out_green    = col[msb_pkg::CH_GREEN];
        res_next.out_blue     = col[msb_pkg::CH_BLUE];
        res_next.write_enable = (alpha_b_reg != msb_pkg::ALPHA_CLEAR);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

// ===== rtl/metal_shine_band_pixel_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// metal_shine_band_pixel_blend
// shine band tint and alpha blend of a sprite pixel stream
// ----------------------------------------------------------------------------
// channels: s_valid/s_ready/s_pixel takes one sprite pixel per transfer,
// m_valid/m_ready/m_result gives one blended pixel per transfer, in order.
// cfg_valid/cfg_ready/cfg_index/cfg_data writes the band registers; cfg_ready
// is always high; the user must make writes go in only while no pixel is in
// flight; the block itself does not enforce this.
// pipeline: 11 register stages (4 band, 4 divider slices of 2 bits each,
// 3 blend).
// throughput: one pixel per cycle while m_ready is high.
// the edge width is derived from the registers through g_prod_reg and g_reg;
// it is read 2 stages into the pipe, so it is settled for a pixel taken
// right after a write.
// reset: empties the pipe and loads the register defaults.
// receiver stall: stages hold, empty stages still fill, so s_ready drops
// only when every stage carries a pixel.
// ----------------------------------------------------------------------------
module metal_shine_band_pixel_blend #(
    parameter int BAND_BITS = msb_pkg::BAND_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  msb_pkg::pix_in_t                      s_pixel,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output msb_pkg::pix_out_t                     m_result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [msb_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [msb_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int NST  = 11;
    localparam int NDIV = 4;
    localparam int GW   = BAND_BITS + 1;
    localparam int PW   = msb_pkg::PCT_BITS + BAND_BITS;
    localparam int MW   = PW + msb_pkg::RECIP_BITS;
    localparam int CHB  = msb_pkg::CHAN_BITS;
    localparam int NCH  = msb_pkg::NCH;

    // band registers
    msb_pkg::dir_t                  direction_reg;
    logic [BAND_BITS-1:0]           band_size_reg;
    logic [msb_pkg::PCT_BITS-1:0]   grad_pct_reg;
    logic [NCH-1:0][CHB-1:0]        bright_reg;
    logic [msb_pkg::POS_BITS-1:0]   band_pos_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= msb_pkg::DIR_ROW;
            band_size_reg <= BAND_BITS'(msb_pkg::BAND_SIZE_RST);
            grad_pct_reg  <= msb_pkg::GRAD_PCT_RST;
            bright_reg    <= {NCH{msb_pkg::BRIGHT_RST}};
            band_pos_reg  <= msb_pkg::POS_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                msb_pkg::REG_DIRECTION:     direction_reg <= msb_pkg::dir_t'(cfg_data[1:0]);
                msb_pkg::REG_BAND_SIZE:     band_size_reg <= cfg_data[BAND_BITS-1:0];
                msb_pkg::REG_GRAD_PERCENT:  grad_pct_reg  <= cfg_data[msb_pkg::PCT_BITS-1:0];
                msb_pkg::REG_BRIGHT_RED:    bright_reg[msb_pkg::CH_RED]   <= cfg_data[CHB-1:0];
                msb_pkg::REG_BRIGHT_GREEN:  bright_reg[msb_pkg::CH_GREEN] <= cfg_data[CHB-1:0];
                msb_pkg::REG_BRIGHT_BLUE:   bright_reg[msb_pkg::CH_BLUE]  <= cfg_data[CHB-1:0];
                msb_pkg::REG_BAND_POSITION: band_pos_reg  <= cfg_data[msb_pkg::POS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // edge width: percent times size, then divide by 100 through the reciprocal
    logic [PW-1:0] g_prod_reg;
    logic [MW-1:0] g_mul;
    logic [GW-1:0] g_reg;

    assign g_mul = MW'(g_prod_reg) * MW'(msb_pkg::GRAD_RECIP);

    always_ff @(posedge aclk) begin
        g_prod_reg <= PW'(grad_pct_reg) * PW'(band_size_reg);
        g_reg      <= g_mul[msb_pkg::GRAD_SHIFT +: GW];
    end

    // pipeline valid bits and stage advance
    logic [NST-1:0] vld_reg, vld_next;
    logic [NST:0]   adv;

    always_comb begin
        adv[NST] = m_ready;
        for (int i = NST - 1; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        vld_next[0] = adv[0] ? s_valid : vld_reg[0];
        for (int i = 1; i < NST; i++) begin
            vld_next[i] = adv[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = adv[0];
    assign m_valid = vld_reg[NST-1];

    // datapath
    msb_pkg::pix_carry_t                   carry_d [NDIV+1];
    msb_pkg::tint_ctl_t                    ctl_d   [NDIV+1];
    logic [NCH-1:0][GW-1:0]                rem_d   [NDIV+1];
    logic [NCH-1:0][CHB-1:0]               nb_d    [NDIV+1];
    logic [NCH-1:0][CHB-1:0]               q_d     [NDIV+1];

    assign q_d[0] = '0;

    msb_band #(
        .BAND_BITS (BAND_BITS)
    ) u_band (
        .aclk          (aclk),
        .stage_en      (adv[3:0]),
        .pix_in        (s_pixel),
        .direction     (direction_reg),
        .band_size     (band_size_reg),
        .band_position (band_pos_reg),
        .grad          (g_reg),
        .bright        (bright_reg),
        .carry_out     (carry_d[0]),
        .ctl_out       (ctl_d[0]),
        .rem_out       (rem_d[0]),
        .nb_out        (nb_d[0])
    );

    for (genvar j = 0; j < NDIV; j++) begin : g_div
        msb_div_stage #(
            .BAND_BITS (BAND_BITS),
            .STEPS     (CHB / NDIV)
        ) u_div (
            .aclk      (aclk),
            .stage_en  (adv[4+j]),
            .grad      (g_reg),
            .carry_in  (carry_d[j]),
            .ctl_in    (ctl_d[j]),
            .rem_in    (rem_d[j]),
            .nb_in     (nb_d[j]),
            .q_in      (q_d[j]),
            .carry_out (carry_d[j+1]),
            .ctl_out   (ctl_d[j+1]),
            .rem_out   (rem_d[j+1]),
            .nb_out    (nb_d[j+1]),
            .q_out     (q_d[j+1])
        );
    end

    msb_blend u_blend (
        .aclk     (aclk),
        .stage_en (adv[NST-1:NST-3]),
        .carry_in (carry_d[NDIV]),
        .ctl_in   (ctl_d[NDIV]),
        .q_in     (q_d[NDIV]),
        .bright   (bright_reg),
        .result   (m_result)
    );

    // checks
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_ready || !m_valid) |-> s_ready)
        else $error("input stalled although the pipe can move");

    a_transfer_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[0])
        else $error("input transfer not captured in first stage");

    a_grad_width: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn, 3) |->
            ((32'(g_reg) * 32'd100 <= 32'($past(g_prod_reg))) &&
             (32'($past(g_prod_reg)) < (32'(g_reg) + 32'd1) * 32'd100)))
        else $error("edge width does not match percent of band size");

endmodule
